// ===== hdl/mm_pkg.sv =====
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam int FIELD_W   = 32;	// width of value and product ports
	localparam int IDX_W     = 3;	// width of row / column ports
	localparam int CFG_W     = 4;	// width of a dimension register
	localparam int CFG_IDX_W = 2;	// width of the register index
	localparam int FRAC_BITS = 16;	// Q16.16
	localparam int CMD_DEPTH = 4;	// command queue between front and back
	localparam int RES_DEPTH = 4;	// result queue at the output

	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// input mode codes
	localparam logic [1:0] MODE_WR_A    = 2'd0;
	localparam logic [1:0] MODE_WR_B    = 2'd1;
	localparam logic [1:0] MODE_COMPUTE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

	typedef enum logic [1:0] {
		OP_WR_A,
		OP_WR_B,
		OP_COMPUTE
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [FIELD_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]   row;
		logic [IDX_W-1:0]   col;
		logic [FIELD_W-1:0] product;
		logic               last;
	} res_t;

endpackage

// ===== hdl/matrix_multiply_top.sv =====
// ----------------------------------------------------------------------------
// matrix_multiply_top
// Fixed-point matrix multiply: loads A and B element by element, then
// streams C = A * B in row-major order.
// ----------------------------------------------------------------------------
// Usage:
// Input items enter through push/full; mode selects a write of A, a write of
// B, or a compute. Writes outside MAX_DIM and mode 3 are dropped. Results
// leave through empty/pop, oldest first, with last set on the final element.
// The user writes dimensions on the cfg channel (always ready) only while
// idle; the block does not enforce this. A write item is written into its
// store when the idle back end takes it from the command queue. A compute
// item walks one multiply-accumulate unit, one term per cycle as the single
// read port of each store allows, holding before a dot product while the
// result queue has no room for it.
// Command and result queues each hold 4 entries. When the receiver stalls,
// the result queue fills, the walk holds at the next dot product, then the
// command queue fills and full rises.
// Reset empties both queues and sets all dimensions to 8; the A and B
// stores hold no defined contents until written.
// ----------------------------------------------------------------------------
module matrix_multiply_top import mm_pkg::*; #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           mode,
	input  logic [IDX_W-1:0]     row,
	input  logic [IDX_W-1:0]     col,
	input  logic [FIELD_W-1:0]   value,
	output logic                 empty,
	input  logic                 pop,
	output logic [IDX_W-1:0]     out_row,
	output logic [IDX_W-1:0]     out_col,
	output logic [FIELD_W-1:0]   product,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_size_q;
	logic [CFG_W-1:0] cols_b_q;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;
	res_t             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= DIM_RESET;
			inner_size_q <= DIM_RESET;
			cols_b_q     <= DIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROWS_A:     rows_a_q     <= cfg_data;
				REG_INNER_SIZE: inner_size_q <= cfg_data;
				REG_COLS_B:     cols_b_q     <= cfg_data;
				default: begin
					// unknown index: drop
				end
			endcase
		end
	end

	mm_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.mode      (mode),
		.row       (row),
		.col       (col),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	mm_back #(
		.MAX_DIM     (MAX_DIM),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.rows_a     (rows_a_q),
		.inner_size (inner_size_q),
		.cols_b     (cols_b_q),
		.res_pop    (pop),
		.res_empty  (empty),
		.res        (res)
	);

	assign out_row = res.row;
	assign out_col = res.col;
	assign product = res.product;
	assign last    = res.last;

endmodule

// ===== hdl/mm_ram.sv =====
// ----------------------------------------------------------------------------
// mm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/mm_fifo.sv =====
// ----------------------------------------------------------------------------
// mm_fifo
// Small synchronous queue with fill count, used for commands and results.
// ----------------------------------------------------------------------------
module mm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       full,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/mm_front.sv =====
// ----------------------------------------------------------------------------
// mm_front
// Accepts input items, drops unused modes and out-of-range writes, and
// queues the rest as commands for the back end.
// ----------------------------------------------------------------------------
module mm_front import mm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         mode,
	input  logic [IDX_W-1:0]   row,
	input  logic [IDX_W-1:0]   col,
	input  logic [FIELD_W-1:0] value,
	output logic               cmd_valid,
	output cmd_t               cmd,
	input  logic               cmd_pop
);

	localparam logic [5:0] MAXD = 6'(MAX_DIM);

	cmd_t                           cmd_in;
	logic                           keep;
	logic                           in_range;
	logic                           cmd_empty;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

	assign in_range = ({3'b000, row} < MAXD) && ({3'b000, col} < MAXD);

	always_comb begin
		cmd_in.row   = row;
		cmd_in.col   = col;
		cmd_in.value = value;
		cmd_in.op    = OP_COMPUTE;
		keep         = 1'b0;
		case (mode)
			MODE_WR_A: begin
				cmd_in.op = OP_WR_A;
				keep      = in_range;
			end
			MODE_WR_B: begin
				cmd_in.op = OP_WR_B;
				keep      = in_range;
			end
			MODE_COMPUTE: begin
				cmd_in.op = OP_COMPUTE;
				keep      = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	mm_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && keep),
		.wdata  (cmd_in),
		.pop    (cmd_pop),
		.rdata  (cmd),
		.full   (full),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	assign cmd_valid = !cmd_empty;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_count <= ($clog2(CMD_DEPTH+1))'(CMD_DEPTH))
		else $error("command queue count out of bounds");
	a_drop_no_enq: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && !keep) |=> (cmd_count == $past(cmd_count) - (($past(cmd_pop)
		&& $past(cmd_valid)) ? 1'b1 : 1'b0)))
		else $error("dropped item entered command queue");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");
`endif

endmodule

// ===== hdl/mm_back.sv =====
// ----------------------------------------------------------------------------
// mm_back
// Executes commands: writes into the A and B stores, and walks a compute
// through one multiply-accumulate pipeline into the result queue.
// ----------------------------------------------------------------------------
module mm_back import mm_pkg::*; #(
	parameter int MAX_DIM     = 8,
	parameter int VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  cmd_t             cmd,
	output logic             cmd_pop,
	input  logic [CFG_W-1:0] rows_a,
	input  logic [CFG_W-1:0] inner_size,
	input  logic [CFG_W-1:0] cols_b,
	input  logic             res_pop,
	output logic             res_empty,
	output res_t             res
);

	localparam int DW   = $clog2(MAX_DIM);
	localparam int AW   = 2 * DW;
	localparam int PW   = 2 * VALUE_WIDTH;
	localparam int ACW  = PW + DW + 1;
	localparam int CNTW = $clog2(RES_DEPTH + 1);

	localparam logic signed [ACW-1:0] SAT_HI = ACW'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [ACW-1:0] SAT_LO = -SAT_HI - ACW'(1);

	typedef enum logic {S_IDLE, S_RUN} state_t;

	typedef struct packed {
		logic          valid;
		logic          first;
		logic          lastk;
		logic          lastel;
		logic [DW-1:0] row;
		logic [DW-1:0] col;
	} mac_ctrl_t;

	function automatic logic [DW-1:0] last_idx(input logic [CFG_W-1:0] d);
		logic [5:0] w;
		w = {2'b00, d};
		if (w == '0) return '0;
		if (w > 6'(MAX_DIM)) return DW'(MAX_DIM - 1);
		return DW'(w - 6'd1);
	endfunction

	state_t        state_q;
	logic [DW-1:0] r_q;
	logic [DW-1:0] c_q;
	logic [DW-1:0] k_q;
	logic [DW-1:0] r_last;
	logic [DW-1:0] c_last;
	logic [DW-1:0] k_last;
	logic          issue;
	logic          credit_ok;
	logic [CNTW-1:0] outstanding_q;
	logic [CNTW-1:0] res_count;
	logic            res_full;
	logic            res_push;
	res_t            res_in;

	mac_ctrl_t ctrl_s0;
	mac_ctrl_t ctrl_s1;
	mac_ctrl_t ctrl_s2;
	mac_ctrl_t ctrl_s3;

	logic [VALUE_WIDTH-1:0]    a_s1;
	logic [VALUE_WIDTH-1:0]    b_s1;
	logic signed [PW-1:0]      prod_s2;
	logic signed [ACW-1:0]     acc_s3;
	logic signed [ACW-1:0]     shifted;
	logic signed [VALUE_WIDTH-1:0] sat_v;

	logic          wa_en;
	logic          wb_en;
	logic [AW-1:0] waddr;

	assign r_last = last_idx(rows_a);
	assign c_last = last_idx(cols_b);
	assign k_last = last_idx(inner_size);

	// a new dot product starts only when the result queue has room for it
	assign credit_ok = ({1'b0, res_count} + {1'b0, outstanding_q}) < (CNTW+1)'(RES_DEPTH);
	assign issue     = (state_q == S_RUN) && ((k_q != '0) || credit_ok);
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;

	assign wa_en = cmd_pop && (cmd.op == OP_WR_A);
	assign wb_en = cmd_pop && (cmd.op == OP_WR_B);
	assign waddr = {DW'(cmd.row), DW'(cmd.col)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid && cmd.op == OP_COMPUTE) begin
						state_q <= S_RUN;
						r_q     <= '0;
						c_q     <= '0;
						k_q     <= '0;
					end
				end
				S_RUN: begin
					if (issue) begin
						if (k_q == k_last) begin
							k_q <= '0;
							if (c_q == c_last) begin
								c_q <= '0;
								if (r_q == r_last) begin
									r_q     <= '0;
									state_q <= S_IDLE;
								end else begin
									r_q <= r_q + 1'b1;
								end
							end else begin
								c_q <= c_q + 1'b1;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctrl_s0.valid  = issue;
		ctrl_s0.first  = (k_q == '0);
		ctrl_s0.lastk  = (k_q == k_last);
		ctrl_s0.lastel = (r_q == r_last) && (c_q == c_last);
		ctrl_s0.row    = r_q;
		ctrl_s0.col    = c_q;
	end

	mm_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (1 << AW)
	) u_store_a (
		.clk   (clk),
		.we    (wa_en),
		.waddr (waddr),
		.wdata (cmd.value[VALUE_WIDTH-1:0]),
		.raddr ({r_q, k_q}),
		.rdata (a_s1)
	);

	mm_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (1 << AW)
	) u_store_b (
		.clk   (clk),
		.we    (wb_en),
		.waddr (waddr),
		.wdata (cmd.value[VALUE_WIDTH-1:0]),
		.raddr ({k_q, c_q}),
		.rdata (b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1 <= ctrl_s0;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_s1) * $signed(b_s1);
		if (ctrl_s2.valid) begin
			acc_s3 <= ctrl_s2.first ? ACW'(prod_s2) : acc_s3 + ACW'(prod_s2);
		end
	end

	// floor to Q16.16, then clip to the value range
	always_comb begin
		shifted = acc_s3 >>> FRAC_BITS;
		if (shifted > SAT_HI) begin
			sat_v = VALUE_WIDTH'(SAT_HI);
		end else if (shifted < SAT_LO) begin
			sat_v = VALUE_WIDTH'(SAT_LO);
		end else begin
			sat_v = VALUE_WIDTH'(shifted);
		end
	end

	assign res_push       = ctrl_s3.valid && ctrl_s3.lastk;
	assign res_in.row     = IDX_W'(ctrl_s3.row);
	assign res_in.col     = IDX_W'(ctrl_s3.col);
	assign res_in.product = FIELD_W'(sat_v);
	assign res_in.last    = ctrl_s3.lastel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			case ({issue && ctrl_s0.first, res_push})
				2'b10:   outstanding_q <= outstanding_q + 1'b1;
				2'b01:   outstanding_q <= outstanding_q - 1'b1;
				default: outstanding_q <= outstanding_q;
			endcase
		end
	end

	mm_fifo #(
		.WIDTH ($bits(res_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (res_pop),
		.rdata  (res),
		.full   (res_full),
		.empty  (res_empty),
		.count  (res_count)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, res_count} + {1'b0, outstanding_q}) <= (CNTW+1)'(RES_DEPTH))
		else $error("result credit exceeded");
	a_push_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (outstanding_q != '0))
		else $error("result pushed with nothing outstanding");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> (state_q == S_IDLE))
		else $error("command taken during a compute walk");
`endif

endmodule
